// File: src/sphere_stamp_volume_max_core_macros.svh
// assertion helpers used by the core's self-checks
`ifndef SPHERE_STAMP_VOLUME_MAX_CORE_MACROS_SVH
`define SPHERE_STAMP_VOLUME_MAX_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SSVM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SSVM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ssvm_pkg.sv
`default_nettype none
package ssvm_pkg;

	// command codes of an input transaction
	typedef enum logic [1:0] {
		CMD_STAMP = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_RADIUS      = 3'd0,
		CFG_STAMP_VALUE = 3'd1,
		CFG_DIM_I       = 3'd2,
		CFG_DIM_J       = 3'd3,
		CFG_DIM_K       = 3'd4
	} cfg_reg_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic start;
		logic step;
		logic load_result;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic sweep_last;
		logic busy;
	} ctrl_stat_t;

endpackage
`default_nettype wire

// File: src/ssvm_ctrl.sv
`default_nettype none
module ssvm_ctrl
	import ssvm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output ctrl_cmd_t       cmd,
	input  wire ctrl_stat_t stat
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	// state and result flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register holds until the transaction is taken
	always_comb begin
		if (cmd.load_result) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: src/ssvm_datapath.sv
`default_nettype none
module ssvm_datapath
	import ssvm_pkg::*;
#(
	parameter int MAX_I      = 64,
	parameter int MAX_J      = 64,
	parameter int MAX_K      = 64,
	parameter int VOXEL_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output ctrl_stat_t             stat,
	input  wire logic        [1:0] command,
	input  wire logic signed [7:0] pos_i,
	input  wire logic signed [7:0] pos_j,
	input  wire logic signed [7:0] pos_k,
	input  wire logic        [7:0] write_value,
	input  wire logic        [3:0] radius,
	input  wire logic        [7:0] stamp_value,
	input  wire logic        [6:0] dim_i,
	input  wire logic        [6:0] dim_j,
	input  wire logic        [6:0] dim_k,
	output logic             [7:0] read_value,
	output logic            [14:0] voxels_touched,
	output logic                   status
);

	localparam int DEPTH = MAX_I * MAX_J * MAX_K;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = (AW > 22) ? AW : 22;

	logic [VOXEL_BITS-1:0] mem [DEPTH];
	logic [AW-1:0]         clr_addr_q;

	// transaction fields held for the sweep
	logic        [1:0]            op_q;
	logic signed [7:0]            pi_q, pj_q, pk_q;
	logic        [VOXEL_BITS-1:0] wv_q, sv_q;
	logic signed [4:0]            r_q;
	logic        [9:0]            r2_q;
	logic        [6:0]            dimi_q, dimj_q, dimk_q;
	logic        [13:0]           stride_k_q;

	// offset counters, j fastest
	logic signed [4:0] oi_q, oj_q, ok_q;

	logic        [3:0] r_start;
	logic        [7:0] r_sq;
	logic signed [4:0] r_signed;

	// offset decode
	logic signed [8:0] ci_c, cj_c, ck_c;
	logic signed [9:0] oi_w, oj_w, ok_w;
	logic        [9:0] sq_c;
	logic              in_c, hit_c;

	// pipeline
	logic              valid_s1, valid_s2, valid_s3;
	logic              hit_s1, hit_s2, hit_s3;
	logic        [6:0] ci_s1, cj_s1, ck_s1;
	logic       [14:0] pij_s2;
	logic       [20:0] pk_s2;
	logic [SUM_W-1:0]  addr_c;
	logic [AW-1:0]     addr_s3;
	logic [VOXEL_BITS-1:0] rdata_q;

	// write port
	logic                  wen;
	logic [AW-1:0]         waddr;
	logic [VOXEL_BITS-1:0] wdata;

	// per transaction results
	logic  [7:0] rd_q;
	logic [14:0] touched_q;
	logic        err_q;
	logic  [7:0] res_read_q;
	logic [14:0] res_touched_q;
	logic        res_status_q;

	assign r_start  = (command == CMD_STAMP) ? radius : 4'd0;
	assign r_sq     = r_start * r_start;
	assign r_signed = signed'({1'b0, r_start});

	// latch the transaction at start
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q       <= command;
			pi_q       <= pos_i;
			pj_q       <= pos_j;
			pk_q       <= pos_k;
			wv_q       <= VOXEL_BITS'(write_value);
			sv_q       <= VOXEL_BITS'(stamp_value);
			r_q        <= r_signed;
			r2_q       <= {2'b00, r_sq};
			dimi_q     <= dim_i;
			dimj_q     <= dim_j;
			dimk_q     <= dim_k;
			stride_k_q <= 14'(dim_i) * 14'(dim_j);
		end
	end

	// offset sweep over the cube
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			oi_q <= -r_signed;
			oj_q <= -r_signed;
			ok_q <= -r_signed;
		end else if (cmd.step) begin
			if (oj_q == r_q) begin
				oj_q <= -r_q;
				if (oi_q == r_q) begin
					oi_q <= -r_q;
					ok_q <= ok_q + 5'sd1;
				end else begin
					oi_q <= oi_q + 5'sd1;
				end
			end else begin
				oj_q <= oj_q + 5'sd1;
			end
		end
	end

	// target position, bounds and sphere test
	assign ci_c = 9'(pi_q) + 9'(oi_q);
	assign cj_c = 9'(pj_q) + 9'(oj_q);
	assign ck_c = 9'(pk_q) + 9'(ok_q);
	assign oi_w = 10'(oi_q);
	assign oj_w = 10'(oj_q);
	assign ok_w = 10'(ok_q);
	assign sq_c = 10'(oi_w * oi_w + oj_w * oj_w + ok_w * ok_w);
	assign in_c = !ci_c[8] && (ci_c[7:0] < {1'b0, dimi_q}) &&
	              !cj_c[8] && (cj_c[7:0] < {1'b0, dimj_q}) &&
	              !ck_c[8] && (ck_c[7:0] < {1'b0, dimk_q});
	assign hit_c = in_c && (sq_c <= r2_q);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1 coordinates, stage 2 products, stage 3 address
	always_ff @(posedge clk) begin
		hit_s1  <= hit_c;
		ci_s1   <= ci_c[6:0];
		cj_s1   <= cj_c[6:0];
		ck_s1   <= ck_c[6:0];
		hit_s2  <= hit_s1;
		pij_s2  <= 15'(ci_s1) * 15'(dimj_q) + 15'(cj_s1);
		pk_s2   <= 21'(ck_s1) * 21'(stride_k_q);
		hit_s3  <= hit_s2;
		addr_s3 <= addr_c[AW-1:0];
	end

	assign addr_c = SUM_W'(pij_s2) + SUM_W'(pk_s2);

	// write port: clearing pass, plain write, or merge of the registered read
	always_comb begin
		wen   = 1'b0;
		waddr = addr_s3;
		wdata = wv_q;
		if (cmd.clear) begin
			wen   = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (valid_s3 && hit_s3) begin
			if (op_q == CMD_STAMP) begin
				wen   = 1'b1;
				wdata = (rdata_q > sv_q) ? rdata_q : sv_q;
			end else if (op_q == CMD_WRITE) begin
				wen = 1'b1;
			end
		end
	end

	// voxel memory
	always_ff @(posedge clk) begin
		rdata_q <= mem[addr_c[AW-1:0]];
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// touched count, status and read data of the running transaction
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			touched_q <= '0;
			err_q     <= 1'b0;
			rd_q      <= '0;
		end else begin
			if (cmd.step && op_q == CMD_STAMP && hit_c) begin
				touched_q <= touched_q + 15'd1;
			end
			if (cmd.step && (op_q == CMD_READ || op_q == CMD_WRITE)) begin
				err_q <= !in_c;
			end
			if (valid_s3 && hit_s3 && op_q == CMD_READ) begin
				rd_q <= 8'(rdata_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_read_q    <= rd_q;
			res_touched_q <= touched_q;
			res_status_q  <= err_q;
		end
	end

	assign stat.clear_last = (clr_addr_q == AW'(DEPTH - 1));
	assign stat.sweep_last = (oi_q == r_q) && (oj_q == r_q) && (ok_q == r_q);
	assign stat.busy       = valid_s1 || valid_s2 || valid_s3;

	assign read_value     = res_read_q;
	assign voxels_touched = res_touched_q;
	assign status         = res_status_q;

endmodule
`default_nettype wire

// File: src/sphere_stamp_volume_max_core.sv
// a stamp of radius r sweeps (2r+1)^3 offsets, a read or write a single one;
// a new transaction is taken only once the last result is loaded; the stamp
// sweep issues one voxel read-modify-write per cycle through the voxel memory's
// read and write ports; reset is asynchronous active-low, then a clearing pass
// zeroes the volume, with in_stall high until it ends; config writes always taken
`default_nettype none
`include "sphere_stamp_volume_max_core_macros.svh"
module sphere_stamp_volume_max_core
	import ssvm_pkg::*;
#(
	parameter int MAX_I      = 64,
	parameter int MAX_J      = 64,
	parameter int MAX_K      = 64,
	parameter int MAX_RADIUS = 15,
	parameter int VOXEL_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic        [1:0] command,
	input  wire logic signed [7:0] pos_i,
	input  wire logic signed [7:0] pos_j,
	input  wire logic signed [7:0] pos_k,
	input  wire logic        [7:0] write_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic             [7:0] read_value,
	output logic            [14:0] voxels_touched,
	output logic                   status,
	input  wire logic              cfg_write_en,
	input  wire logic        [2:0] cfg_index,
	input  wire logic        [7:0] cfg_data
);

	localparam logic [6:0] DIM_I_RST  = 7'((MAX_I < 64) ? MAX_I : 64);
	localparam logic [6:0] DIM_J_RST  = 7'((MAX_J < 64) ? MAX_J : 64);
	localparam logic [6:0] DIM_K_RST  = 7'((MAX_K < 64) ? MAX_K : 64);

	logic [3:0] radius_q;
	logic [7:0] stamp_value_q;
	logic [6:0] dim_i_q, dim_j_q, dim_k_q;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// configuration registers, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= 4'd1;
			stamp_value_q <= 8'd1;
			dim_i_q       <= DIM_I_RST;
			dim_j_q       <= DIM_J_RST;
			dim_k_q       <= DIM_K_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_RADIUS: begin
					if (int'(cfg_data[3:0]) > MAX_RADIUS) begin
						radius_q <= 4'(MAX_RADIUS);
					end else begin
						radius_q <= cfg_data[3:0];
					end
				end
				CFG_STAMP_VALUE: begin
					stamp_value_q <= cfg_data;
				end
				CFG_DIM_I: begin
					if (int'(cfg_data[6:0]) > MAX_I) begin
						dim_i_q <= 7'(MAX_I);
					end else begin
						dim_i_q <= cfg_data[6:0];
					end
				end
				CFG_DIM_J: begin
					if (int'(cfg_data[6:0]) > MAX_J) begin
						dim_j_q <= 7'(MAX_J);
					end else begin
						dim_j_q <= cfg_data[6:0];
					end
				end
				CFG_DIM_K: begin
					if (int'(cfg_data[6:0]) > MAX_K) begin
						dim_k_q <= 7'(MAX_K);
					end else begin
						dim_k_q <= cfg_data[6:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// controller
	ssvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath with voxel memory
	ssvm_datapath #(
		.MAX_I      (MAX_I),
		.MAX_J      (MAX_J),
		.MAX_K      (MAX_K),
		.VOXEL_BITS (VOXEL_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.command        (command),
		.pos_i          (pos_i),
		.pos_j          (pos_j),
		.pos_k          (pos_k),
		.write_value    (write_value),
		.radius         (radius_q),
		.stamp_value    (stamp_value_q),
		.dim_i          (dim_i_q),
		.dim_j          (dim_j_q),
		.dim_k          (dim_k_q),
		.read_value     (read_value),
		.voxels_touched (voxels_touched),
		.status         (status)
	);

	// checks
	`SSVM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
	`SSVM_ASSERT_NOW(a_load_when_drained, cmd.load_result, !stat.busy, "result before drain")
	`SSVM_ASSERT_NOW(a_error_clean, out_valid && status, voxels_touched == 15'd0 && read_value == 8'd0, "error result carries data")

endmodule
`default_nettype wire

// File: test/sphere_stamp_checker.sv
`timescale 1ns / 100ps
module sphere_stamp_checker
	import ssvm_pkg::*;
#(
	parameter int MAX_I      = 64,
	parameter int MAX_J      = 64,
	parameter int MAX_K      = 64,
	parameter int MAX_RADIUS = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic        [1:0] command,
	input  wire logic signed [7:0] pos_i,
	input  wire logic signed [7:0] pos_j,
	input  wire logic signed [7:0] pos_k,
	input  wire logic        [7:0] write_value,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic        [7:0] read_value,
	input  wire logic       [14:0] voxels_touched,
	input  wire logic              status,
	input  wire logic              cfg_write_en,
	input  wire logic        [2:0] cfg_index,
	input  wire logic        [7:0] cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int VOXELS = MAX_I * MAX_J * MAX_K;

	typedef struct packed {
		logic  [7:0] read_value;
		logic [14:0] voxels_touched;
		logic        status;
	} voxel_reply_t;

	// shadow volume and settings
	logic [7:0] shadow_volume [VOXELS];
	int radius_q, stamp_q, ext_i, ext_j, ext_k;
	voxel_reply_t replies_due [$];

	function automatic int clip_extent(input logic [7:0] data, input int lim);
		int d;
		d = int'(data[6:0]);
		return (d > lim) ? lim : d;
	endfunction

	function automatic bit in_volume(input int i, input int j, input int k);
		return i >= 0 && i < ext_i && j >= 0 && j < ext_j && k >= 0 && k < ext_k;
	endfunction

	// j fastest, then i, then k, with strides from the current extents
	function automatic int voxel_addr(input int i, input int j, input int k);
		return j + i * ext_j + k * ext_i * ext_j;
	endfunction

	// max-merge the sphere into the shadow volume, count merged voxels
	function automatic int stamp_sphere(input int ci, input int cj, input int ck);
		int n, a;
		n = 0;
		for (int dk = -radius_q; dk <= radius_q; dk++)
			for (int di = -radius_q; di <= radius_q; di++)
				for (int dj = -radius_q; dj <= radius_q; dj++) begin
					if (di * di + dj * dj + dk * dk <= radius_q * radius_q &&
							in_volume(ci + di, cj + dj, ck + dk)) begin
						a = voxel_addr(ci + di, cj + dj, ck + dk);
						if (shadow_volume[a] < stamp_q[7:0])
							shadow_volume[a] = stamp_q[7:0];
						n++;
					end
				end
		return n;
	endfunction

	// apply one command to the shadow volume and form its reply
	function automatic voxel_reply_t run_command(input logic [1:0] cmd, input int pi,
			input int pj, input int pk, input logic [7:0] wv);
		voxel_reply_t rep;
		int n;
		rep = '0;
		case (cmd)
			CMD_STAMP: begin
				n = stamp_sphere(pi, pj, pk);
				rep.voxels_touched = n[14:0];
			end
			CMD_READ: begin
				if (in_volume(pi, pj, pk))
					rep.read_value = shadow_volume[voxel_addr(pi, pj, pk)];
				else
					rep.status = 1'b1;
			end
			CMD_WRITE: begin
				if (in_volume(pi, pj, pk))
					shadow_volume[voxel_addr(pi, pj, pk)] = wv;
				else
					rep.status = 1'b1;
			end
			default: ;
		endcase
		return rep;
	endfunction

	function automatic void set_register(input logic [2:0] idx, input logic [7:0] data);
		case (idx)
			CFG_RADIUS:
				radius_q = (int'(data[3:0]) > MAX_RADIUS) ? MAX_RADIUS : int'(data[3:0]);
			CFG_STAMP_VALUE: stamp_q = int'(data);
			CFG_DIM_I:       ext_i = clip_extent(data, MAX_I);
			CFG_DIM_J:       ext_j = clip_extent(data, MAX_J);
			CFG_DIM_K:       ext_k = clip_extent(data, MAX_K);
			default: ;
		endcase
	endfunction

	function automatic void compare_field(input string field, input logic [14:0] want,
			input logic [14:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// state after reset
	initial begin
		for (int a = 0; a < VOXELS; a++)
			shadow_volume[a] = 8'd0;
		radius_q = 1;
		stamp_q = 1;
		ext_i = clip_extent(8'd64, MAX_I);
		ext_j = clip_extent(8'd64, MAX_J);
		ext_k = clip_extent(8'd64, MAX_K);
		mismatches = 0;
		outstanding = 0;
	end

	// retire finished transactions, then predict the newly accepted one
	always @(posedge clk) begin
		voxel_reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					compare_field("read_value", 15'(want.read_value), 15'(read_value));
					compare_field("voxels_touched", want.voxels_touched, voxels_touched);
					compare_field("status", 15'(want.status), 15'(status));
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(run_command(command, int'(pos_i), int'(pos_j),
					int'(pos_k), write_value));
			if (cfg_write_en)
				set_register(cfg_index, cfg_data);
			outstanding = replies_due.size();
		end
	end

endmodule

// File: test/tb_sphere_stamp_volume_max_core.sv
`timescale 1ns / 100ps
module tb_sphere_stamp_volume_max_core;
	import ssvm_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 3000;
	localparam int PHASE_ITEMS   = 25;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic        [1:0] command = CMD_STAMP;
	logic signed [7:0] pos_i = '0;
	logic signed [7:0] pos_j = '0;
	logic signed [7:0] pos_k = '0;
	logic        [7:0] write_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic        [7:0] read_value;
	logic       [14:0] voxels_touched;
	logic              status;
	logic              cfg_write_en = 1'b0;
	logic        [2:0] cfg_index = CFG_RADIUS;
	logic        [7:0] cfg_data = '0;
	int mismatches;
	int outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_ask = 0;
	int cycle_count = 0;
	// settings as the block sees them, used to aim positions
	int eff_radius = 1;
	int eff_i = 64;
	int eff_j = 64;
	int eff_k = 64;
	int last_i = 0;
	int last_j = 0;
	int last_k = 0;

	sphere_stamp_volume_max_core dut (.*);

	sphere_stamp_checker u_check (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sphere_stamp_volume_max_core: done, errors");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int clip_extent(input int data);
		int d;
		d = data & 'h7F;
		return (d > 64) ? 64 : d;
	endfunction

	// mostly inside the volume, sometimes anywhere in the field's range
	function automatic logic signed [7:0] pick_coord(input int extent);
		int sel;
		sel = $urandom_range(99);
		if (sel < 75 && extent > 0)
			return 8'($urandom_range(extent - 1));
		else if (sel < 95)
			return 8'(int'($urandom_range(95)) - 16);
		else
			return 8'($urandom_range(255));
	endfunction

	function automatic logic signed [7:0] near_coord(input int center);
		return 8'(center + int'($urandom_range(2 * eff_radius + 2)) - eff_radius - 1);
	endfunction

	function automatic int pick_extent();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return $urandom_range(8, 1);
		else if (sel < 80)
			return $urandom_range(64, 1);
		else if (sel < 90)
			return 64;
		else if (sel < 95)
			return 0;
		else
			return $urandom_range(255, 65);
	endfunction

	// one register write per falling edge, enable kept high across a burst
	task automatic cfg_put(input logic [2:0] idx, input int val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[7:0];
		@(negedge clk);
	endtask

	task automatic load_settings(input int rad, input int val, input int di, input int dj,
			input int dk);
		cfg_put(CFG_RADIUS, rad);
		cfg_put(CFG_STAMP_VALUE, val);
		cfg_put(CFG_DIM_I, di);
		cfg_put(CFG_DIM_J, dj);
		cfg_put(CFG_DIM_K, dk);
		cfg_write_en <= 1'b0;
		eff_radius = rad & 'hF;
		eff_i = clip_extent(di);
		eff_j = clip_extent(dj);
		eff_k = clip_extent(dk);
	endtask

	// offer one transaction, with random idle cycles ahead of it
	task automatic offer(input logic [1:0] cmd, input logic signed [7:0] pi,
			input logic signed [7:0] pj, input logic signed [7:0] pk, input logic [7:0] wv);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pos_i <= pi;
		pos_j <= pj;
		pos_k <= pk;
		write_value <= wv;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
			@(negedge clk);
		end
	endtask

	// stop sending and let every outstanding result come back
	task automatic settle();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_setup();
		int sel;
		int val;
		sel = $urandom_range(9);
		val = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(254, 1);
		load_settings($urandom_range(4), val, pick_extent(), pick_extent(), pick_extent());
	endtask

	// reads and writes often land near the last sphere
	task automatic random_item();
		logic [1:0] cmd;
		logic signed [7:0] ci, cj, ck;
		logic [7:0] wv;
		int sel;
		sel = $urandom_range(99);
		cmd = (sel < 40) ? CMD_STAMP : (sel < 70) ? CMD_READ :
			(sel < 95) ? CMD_WRITE : CMD_UNUSED;
		if (cmd != CMD_STAMP && $urandom_range(1)) begin
			ci = near_coord(last_i);
			cj = near_coord(last_j);
			ck = near_coord(last_k);
		end else begin
			ci = pick_coord(eff_i);
			cj = pick_coord(eff_j);
			ck = pick_coord(eff_k);
		end
		if (cmd == CMD_STAMP) begin
			last_i = int'(ci);
			last_j = int'(cj);
			last_k = int'(ck);
		end
		sel = $urandom_range(9);
		wv = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
		offer(cmd, ci, cj, ck, wv);
	endtask

	// stimulus
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// settings after reset: radius 1, value 1, full volume
		offer(CMD_READ, 0, 0, 0, 8'h00);
		offer(CMD_STAMP, 0, 0, 0, 8'h00);
		offer(CMD_READ, 0, 0, 0, 8'h00);
		offer(CMD_WRITE, 63, 63, 63, 8'hFF);
		offer(CMD_STAMP, 63, 63, 63, 8'h00);
		offer(CMD_READ, 63, 63, 63, 8'h00);
		offer(CMD_WRITE, 64, 0, 0, 8'h5A);
		offer(CMD_READ, -1, 0, 0, 8'h00);
		offer(CMD_READ, 0, 0, 79, 8'h00);
		offer(CMD_WRITE, -16, -16, -16, 8'hAA);
		offer(CMD_WRITE, 0, 0, 0, 8'h00);
		offer(CMD_READ, 0, 0, 0, 8'h00);
		offer(CMD_UNUSED, 5, 5, 5, 8'h55);
		offer(CMD_STAMP, -16, 79, 32, 8'h00);

		// single-voxel sphere at full value, stamp raises a lower written voxel
		settle();
		load_settings(0, 255, 64, 64, 64);
		offer(CMD_STAMP, 10, 20, 30, 8'h00);
		offer(CMD_WRITE, 10, 20, 30, 8'h7F);
		offer(CMD_STAMP, 10, 20, 30, 8'h00);
		offer(CMD_READ, 10, 20, 30, 8'h00);

		// largest sphere
		settle();
		load_settings(15, 'h80, 64, 64, 64);
		offer(CMD_STAMP, 32, 32, 32, 8'h00);
		offer(CMD_READ, 32, 32, 47, 8'h00);

		// one-voxel-thick slab, oversized extents saturate, radius field wraps
		settle();
		load_settings(20, 0, 1, 127, 200);
		offer(CMD_STAMP, 0, 5, 5, 8'h00);
		offer(CMD_READ, 1, 5, 5, 8'h00);

		// empty volume
		settle();
		load_settings(2, 9, 0, 5, 5);
		offer(CMD_STAMP, 0, 0, 0, 8'h00);
		offer(CMD_READ, 0, 0, 0, 8'h00);

		// random phases with different idling
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 12 == 0) begin
					settle();
					random_setup();
				end
				if (phase == 0 && n == 4)
					hold_ask++;
				random_item();
			end
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("tb_sphere_stamp_volume_max_core: done, clean");
		else
			$display("tb_sphere_stamp_volume_max_core: done, errors");
		$finish;
	end

endmodule
